[hdl/ulp_grace_double_rounding_unit_assert.svh]
// Assertion macros for the grace rounding unit.
// Used by files that include this header; expects clk and rst_n in scope.
`ifndef ULP_GRACE_DOUBLE_ROUNDING_UNIT_ASSERT_SVH
`define ULP_GRACE_DOUBLE_ROUNDING_UNIT_ASSERT_SVH

// Same-cycle implication.
`define UGDR_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define UGDR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[hdl/ugdr_pkg.sv]
// Shared types and constants for the grace rounding unit.
// No dependencies.
package ugdr_pkg;

  localparam int unsigned ModeW = 3;
  localparam int unsigned WordW = 64;

  localparam logic [ModeW-1:0] MODE_FLOOR = 3'd0;
  localparam logic [ModeW-1:0] MODE_CEIL  = 3'd1;
  localparam logic [ModeW-1:0] MODE_ROUND = 3'd2;
  localparam logic [ModeW-1:0] MODE_TRUNC = 3'd3;
  localparam logic [ModeW-1:0] MODE_NUP   = 3'd4;
  localparam logic [ModeW-1:0] MODE_NDN   = 3'd5;

  localparam logic [62:0] INF_MAG   = 63'h7FF0_0000_0000_0000;
  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;

  // captured input item
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [WordW-1:0] bits;
  } item_t;

  // item after the |x| + 0.5 stage
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [WordW-1:0] bits;
    logic [WordW-1:0] half;
  } prep_t;

endpackage

[hdl/ugdr_half.sv]
// First arithmetic stage: |x| + 0.5, round to nearest even.
// Depends on ugdr_pkg. Output only matters for non-integral finite x.
module ugdr_half
  import ugdr_pkg::*;
(
  input  item_t item_i,
  output prep_t prep_o
);

  logic [10:0]  e;
  logic [52:0]  m;
  logic [5:0]   sh;
  logic [53:0]  sum;
  logic [52:0]  kept;
  logic [10:0]  dfull;
  logic [5:0]   ds;
  logic [115:0] t;
  logic [52:0]  n;
  logic         rnd;
  logic [63:0]  half;

  always_comb begin
    e     = item_i.bits[62:52];
    m     = {(e != 11'd0), item_i.bits[51:0]};
    sh    = 6'(11'd1074 - e);
    sum   = {1'b0, m} + (54'd1 << sh);
    kept  = sum[53:1] + 53'(sum[0] & sum[1]);
    dfull = (e == 11'd0) ? 11'd1021 : 11'd1022 - e;
    ds    = (dfull > 11'd63) ? 6'd63 : dfull[5:0];
    t     = {m, 63'b0} >> ds;
    n     = {1'b1, t[114:63]};
    rnd   = t[62] & ((|t[61:0]) | n[0]);
    if (e >= 11'd1022) begin
      // |x| >= 0.5: add in place, at most one carry-out bit
      if (sum[53]) begin
        half = {1'b0, e + 11'd1, kept[51:0]};
      end else begin
        half = {1'b0, e, sum[51:0]};
      end
    end else if (rnd && (&n)) begin
      half = ONE_BITS;
    end else begin
      half = {1'b0, 11'd1022, 52'(n + 53'(rnd))};
    end
    prep_o.mode = item_i.mode;
    prep_o.bits = item_i.bits;
    prep_o.half = half;
  end

endmodule

[hdl/ugdr_round.sv]
// Second arithmetic stage: one-ulp nudge, then floor or ceil on bit patterns.
// Depends on ugdr_pkg.
module ugdr_round
  import ugdr_pkg::*;
(
  input  prep_t       prep_i,
  output logic [63:0] result_o
);

  function automatic logic is_int(input logic [63:0] b);
    logic [62:0] a;
    logic [10:0] e;
    logic [5:0]  f;
    logic [63:0] mask;
    a    = b[62:0];
    e    = a[62:52];
    f    = 6'(11'd1075 - e);
    mask = (64'd1 << f) - 64'd1;
    if (a > INF_MAG) return 1'b0;
    if (a == INF_MAG || a == 63'd0) return 1'b1;
    if (e >= 11'd1075) return 1'b1;
    if (e < 11'd1023) return 1'b0;
    return (a[51:0] & mask[51:0]) == 52'd0;
  endfunction

  // one ulp toward +inf (up) or -inf, nearest-even in the subnormal range
  function automatic logic [63:0] nudge(input logic [63:0] b, input logic up);
    logic [62:0] a;
    logic [62:0] r;
    logic [10:0] e;
    logic [51:0] f;
    a = b[62:0];
    e = a[62:52];
    f = a[51:0];
    r = a;
    if (up != b[63]) begin
      if (e != 11'd0) r = a + 63'd1;
      else if (f[51]) r = a + 63'(f[0]);
    end else begin
      if (e != 11'd0) r = (f == 52'd0 && e >= 11'd2) ? a - 63'd2 : a - 63'd1;
      else if (f[51]) r = a - 63'(f[0]);
    end
    if (a >= INF_MAG || a == 63'd0) r = a;
    return {b[63], r};
  endfunction

  function automatic logic [63:0] fl_ce(input logic [63:0] b, input logic ceil_m);
    logic        neg;
    logic [10:0] e;
    logic [5:0]  f;
    logic [63:0] unit;
    logic [63:0] r;
    neg  = b[63];
    e    = b[62:52];
    f    = 6'(11'd1075 - e);
    unit = 64'd1 << f;
    r    = b & ~(unit - 64'd1);
    if (neg != ceil_m) r = r + unit;
    if (is_int(b)) return b;
    if (e < 11'd1023) begin
      if (ceil_m) return neg ? SIGN_BIT : ONE_BITS;
      return neg ? (SIGN_BIT | ONE_BITS) : 64'd0;
    end
    return r;
  endfunction

  logic [63:0] b;
  logic [63:0] w;
  logic        nan;
  logic        bint;
  logic [63:0] wfl;

  always_comb begin
    b    = prep_i.bits;
    w    = prep_i.half;
    nan  = b[62:0] > INF_MAG;
    bint = is_int(b);
    wfl  = is_int(w) ? w : fl_ce(nudge(w, 1'b1), 1'b0);
    case (prep_i.mode)
      MODE_FLOOR: begin
        result_o = nan ? (b | QUIET_BIT) : bint ? b : fl_ce(nudge(b, 1'b1), 1'b0);
      end
      MODE_CEIL: begin
        result_o = nan ? (b | QUIET_BIT) : bint ? b : fl_ce(nudge(b, 1'b0), 1'b1);
      end
      MODE_ROUND: begin
        if (bint) result_o = b;
        else if (nan) result_o = {1'b0, b[62:0]} | QUIET_BIT;
        else result_o = wfl | {b[63], 63'd0};
      end
      MODE_TRUNC: begin
        if (nan) result_o = b | QUIET_BIT;
        else if (bint) result_o = b;
        else result_o = {b[63], 63'd0} | fl_ce(nudge({1'b0, b[62:0]}, 1'b1), 1'b0);
      end
      MODE_NUP: result_o = nudge(b, 1'b1);
      MODE_NDN: result_o = nudge(b, 1'b0);
      default:  result_o = b;
    endcase
  end

endmodule

[hdl/ulp_grace_double_rounding_unit.sv]
// Top level of the grace rounding unit: pipeline registers and handshake.
// Depends on ugdr_pkg, ugdr_half, ugdr_round and the assertion header.
//
// Takes one binary64 operand and a mode per item (floor, ceil, round half
// away from zero, trunc, nudge up, nudge down) and returns one binary64 per
// item. The rounding modes first move the operand one ulp toward the integer
// it is meant to be, then round; integral values, zeros and infinities pass
// unchanged, NaNs come back quieted, negative zero is kept. Throughput is one
// item per clock while out_stall is low; the pipeline registers are the input
// register, the register after the |x| + 0.5 stage and the output register.
// Each stage loads when it is empty or its item moves on, so bubbles fill and
// the input keeps accepting while a finished item waits at the output, until all three stages hold an item.
module ulp_grace_double_rounding_unit
  import ugdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [63:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_bits
);

`include "ulp_grace_double_rounding_unit_assert.svh"

  // stage registers
  logic        s1_v_r, s1_v_nxt;
  item_t       s1_r;
  logic        s2_v_r, s2_v_nxt;
  prep_t       s2_r;
  logic        out_v_r, out_v_nxt;
  logic [63:0] out_res_r;

  prep_t       prep;
  logic [63:0] res;
  logic        ld1, ld2, ld3;

  // a stage loads when it is empty or its item moves on
  assign ld3 = !out_v_r || !out_stall;
  assign ld2 = !s2_v_r || ld3;
  assign ld1 = !s1_v_r || ld2;

  assign s1_v_nxt  = ld1 ? in_valid : s1_v_r;
  assign s2_v_nxt  = ld2 ? s1_v_r : s2_v_r;
  assign out_v_nxt = ld3 ? s2_v_r : out_v_r;

  ugdr_half u_half (
    .item_i (s1_r),
    .prep_o (prep)
  );

  ugdr_round u_round (
    .prep_i   (s2_r),
    .result_o (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (ld1 && in_valid) begin
      s1_r.mode <= in_req_type;
      s1_r.bits <= in_value_bits;
    end
    if (ld2 && s1_v_r) begin
      s2_r <= prep;
    end
    if (ld3 && s2_v_r) begin
      out_res_r <= res;
    end
  end

  assign in_stall        = !ld1;
  assign out_valid       = out_v_r;
  assign out_result_bits = out_res_r;

  // stall only when every stage holds an item
  `UGDR_ASSERT_NOW(a_stall_full, in_stall, s1_v_r && s2_v_r && out_v_r, "stall with free stage")
  // a blocked first stage keeps its item
  `UGDR_ASSERT_NEXT(a_s1_hold, s1_v_r && !ld2, s1_v_r && $stable(s1_r), "stage 1 item lost")
  // floor and ceil of a NaN leave a quiet NaN
  `UGDR_ASSERT_NEXT(a_nan_quiet, s2_v_r && ld3 && (s2_r.mode == MODE_FLOOR || s2_r.mode == MODE_CEIL) && (s2_r.bits[62:0] > INF_MAG), out_result_bits[51], "NaN not quieted")
  // nudge of a zero returns it untouched
  `UGDR_ASSERT_NEXT(a_nudge_zero, s2_v_r && ld3 && (s2_r.mode == MODE_NUP || s2_r.mode == MODE_NDN) && (s2_r.bits[62:0] == 63'd0), out_result_bits == $past(s2_r.bits), "zero nudged")

endmodule
